### rtl/mlt_pkg.sv
// Shared types and constants for the MAC learning table.
`default_nettype none
package mlt_pkg;

  // Field widths fixed by the table entry format
  localparam int unsigned MacW  = 48;
  localparam int unsigned PortW = 4;
  localparam int unsigned AgeW  = 16;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned UsedW = 7;

  // Configuration port geometry
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register reset values
  localparam logic [AgeW-1:0] AgeReloadRst = 16'd300;
  localparam logic [AgeW-1:0] AgeStepRst   = 16'd1;

  // Register indexes
  localparam logic REG_AGE_RELOAD = 1'b0;
  localparam logic REG_AGE_STEP   = 1'b1;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_LEARN   = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_AGE     = 3'd2,
    CMD_FLUSH   = 3'd3,
    CMD_DISABLE = 3'd4
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  // Input word
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [MacW-1:0]  mac_addr;
    logic [PortW-1:0] port_num;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             hit;
    logic [PortW-1:0] port_out;
    logic             status;
    logic [UsedW-1:0] used_count;
  } out_word_t;

  // Aging settings broadcast to every cell
  typedef struct packed {
    logic [AgeW-1:0] age_reload;
    logic [AgeW-1:0] age_step;
  } cfg_t;

  // Command token that walks down the cell chain
  typedef struct packed {
    logic             active;
    logic [CmdW-1:0]  cmd;
    logic             pass;
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
    logic             found;
    logic [PortW-1:0] port_acc;
    logic             placed;
  } tok_t;

endpackage
`default_nettype wire

### rtl/mlt_cfg_regs.sv
// APB register file for the aging settings.
`default_nettype none
module mlt_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlt_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [mlt_pkg::ApbDataW-1:0]  pwdata,
  output logic      [mlt_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  output mlt_pkg::cfg_t                      cfg_o
);

  logic [mlt_pkg::AgeW-1:0] reload_q, reload_d;
  logic [mlt_pkg::AgeW-1:0] step_q, step_d;
  logic                     wr_en;
  logic                     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  // Decode writes and read data
  always_comb begin
    reload_d = reload_q;
    step_d   = step_q;
    prdata   = '0;
    unique case (reg_idx)
      mlt_pkg::REG_AGE_RELOAD: begin
        prdata = {{(mlt_pkg::ApbDataW-mlt_pkg::AgeW){1'b0}}, reload_q};
        if (wr_en) begin
          reload_d = pwdata[mlt_pkg::AgeW-1:0];
        end
      end
      mlt_pkg::REG_AGE_STEP: begin
        prdata = {{(mlt_pkg::ApbDataW-mlt_pkg::AgeW){1'b0}}, step_q};
        if (wr_en) begin
          step_d = pwdata[mlt_pkg::AgeW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= mlt_pkg::AgeReloadRst;
      step_q   <= mlt_pkg::AgeStepRst;
    end else begin
      reload_q <= reload_d;
      step_q   <= step_d;
    end
  end

  assign cfg_o.age_reload = reload_q;
  assign cfg_o.age_step   = step_q;

endmodule
`default_nettype wire

### rtl/mlt_cell.sv
// One table entry: holds an address, port and countdown, and passes the token on.
`default_nettype none
module mlt_cell #(
  parameter int unsigned CntW = 7
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mlt_pkg::cfg_t   cfg_i,
  input  wire mlt_pkg::tok_t   tok_i,
  input  wire logic [CntW-1:0] cnt_i,
  output mlt_pkg::tok_t        tok_o,
  output logic      [CntW-1:0] cnt_o
);

  logic                      valid_q, valid_d;
  logic [mlt_pkg::MacW-1:0]  mac_q, mac_d;
  logic [mlt_pkg::PortW-1:0] port_q, port_d;
  logic [mlt_pkg::AgeW-1:0]  age_q, age_d;
  logic [mlt_pkg::AgeW-1:0]  aged;
  logic                      match;
  logic                      act_q;
  mlt_pkg::tok_t             tok_q, tok_d;
  logic [CntW-1:0]           cnt_q, cnt_d;

  assign match = valid_q && (mac_q == tok_i.mac);
  assign aged  = (age_q > cfg_i.age_step) ? (age_q - cfg_i.age_step) : '0;

  // Apply the passing command to this entry and update the token
  always_comb begin
    valid_d = valid_q;
    mac_d   = mac_q;
    port_d  = port_q;
    age_d   = age_q;
    tok_d   = tok_i;
    if (tok_i.active) begin
      unique case (tok_i.cmd)
        mlt_pkg::CMD_LEARN: begin
          if (!tok_i.pass) begin
            if (match && !tok_i.found) begin
              port_d      = tok_i.port;
              age_d       = cfg_i.age_reload;
              tok_d.found = 1'b1;
            end
          end else if (!tok_i.found && !tok_i.placed && !valid_q) begin
            valid_d      = 1'b1;
            mac_d        = tok_i.mac;
            port_d       = tok_i.port;
            age_d        = cfg_i.age_reload;
            tok_d.placed = 1'b1;
          end
        end
        mlt_pkg::CMD_LOOKUP: begin
          if (match && !tok_i.found) begin
            tok_d.found    = 1'b1;
            tok_d.port_acc = port_q;
          end
        end
        mlt_pkg::CMD_AGE: begin
          if (valid_q) begin
            age_d = aged;
            if (aged == '0) begin
              valid_d = 1'b0;
            end
          end
        end
        mlt_pkg::CMD_FLUSH: begin
          valid_d = 1'b0;
        end
        mlt_pkg::CMD_DISABLE: begin
          if (valid_q && (port_q == tok_i.port)) begin
            age_d = '0;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
    // Add this entry to the running count of live entries
    cnt_d = cnt_i + {{(CntW-1){1'b0}}, valid_d};
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      act_q   <= tok_i.active;
    end
  end

  // Entry and token payload
  always_ff @(posedge clk_i) begin
    mac_q  <= mac_d;
    port_q <= port_d;
    age_q  <= age_d;
    tok_q  <= tok_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = act_q;
  end
  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

### rtl/mac_learning_table_with_aging_top.sv
// Top level of the MAC learning table with aging.
// Usage:
//   Commands arrive as words on the in channel (valid/ready): learn, lookup,
//   age tick, flush and disable port. Each command yields one result word on
//   the out channel (valid/ready): hit, port, full status and live entry count.
//   The aging settings (reload value, step) are at APB byte addresses 0 and 4;
//   write them only while the table is idle (the block does not enforce it).
// Command flow:
//   A command token walks the row of TABLE_ENTRIES cells, passing through each
//   cell's token register in turn; learn makes two walks (match, then insert
//   at the lowest free cell). One command is in the row at a time, so a new
//   word is taken only after the previous command has left the row.
// Reset:
//   All entries become invalid at once, the count reads zero, and the settings
//   return to reload 300 and step 1.
// Stall:
//   A finished result waits in the output register; a second one is held in a
//   pending register and no new word is taken until the output drains.
`default_nettype none
module mac_learning_table_with_aging_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire mlt_pkg::in_word_t             in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output mlt_pkg::out_word_t                 out_word_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlt_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [mlt_pkg::ApbDataW-1:0]  pwdata,
  output logic      [mlt_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  mlt_pkg::cfg_t       cfg;
  mlt_pkg::tok_t       tok_chain [TABLE_ENTRIES+1];
  logic [CntW-1:0]     cnt_chain [TABLE_ENTRIES+1];
  mlt_pkg::tok_t       tok_head;
  logic [CntW-1:0]     cnt_head;
  mlt_pkg::tok_t       tok_last;
  logic [CntW+mlt_pkg::UsedW-1:0] cnt_ext;

  mlt_pkg::state_e     state_q, state_d;
  logic                out_valid_q, out_valid_d;
  mlt_pkg::out_word_t  out_q, out_d;
  mlt_pkg::out_word_t  pend_q, pend_d;
  mlt_pkg::out_word_t  res;
  logic                accept;
  logic                relaunch;
  logic                done;
  logic                is_learn;

  // Configuration registers
  mlt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    mlt_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg),
      .tok_i  (tok_chain[g]),
      .cnt_i  (cnt_chain[g]),
      .tok_o  (tok_chain[g+1]),
      .cnt_o  (cnt_chain[g+1])
    );
  end

  assign tok_last = tok_chain[TABLE_ENTRIES];
  assign is_learn = (tok_last.cmd == mlt_pkg::CMD_LEARN);
  assign accept   = in_valid_i && in_ready_o;
  assign relaunch = tok_last.active && is_learn && !tok_last.pass;
  assign done     = tok_last.active && !(is_learn && !tok_last.pass);

  // Launch a new word, or send a learn back for its insert walk
  always_comb begin
    tok_head = tok_last;
    cnt_head = '0;
    if (relaunch) begin
      tok_head.pass = 1'b1;
    end else begin
      tok_head.active   = accept;
      tok_head.cmd      = in_word_i.cmd;
      tok_head.pass     = 1'b0;
      tok_head.mac      = in_word_i.mac_addr;
      tok_head.port     = in_word_i.port_num;
      tok_head.found    = 1'b0;
      tok_head.port_acc = '0;
      tok_head.placed   = 1'b0;
    end
  end

  assign tok_chain[0] = tok_head;
  assign cnt_chain[0] = cnt_head;

  // Form the result word from the token leaving the row
  assign cnt_ext = {{mlt_pkg::UsedW{1'b0}}, cnt_chain[TABLE_ENTRIES]};
  always_comb begin
    res.hit        = (is_learn || (tok_last.cmd == mlt_pkg::CMD_LOOKUP)) && tok_last.found;
    res.port_out   = (tok_last.cmd == mlt_pkg::CMD_LOOKUP) ? tok_last.port_acc : '0;
    res.status     = is_learn && !tok_last.found && !tok_last.placed;
    res.used_count = cnt_ext[mlt_pkg::UsedW-1:0];
  end

  // Sequence commands and hand results to the output register
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = (state_q == mlt_pkg::ST_IDLE);
    unique case (state_q)
      mlt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = mlt_pkg::ST_RUN;
        end
      end
      mlt_pkg::ST_RUN: begin
        if (done) begin
          if (!out_valid_q || out_ready_i) begin
            out_d       = res;
            out_valid_d = 1'b1;
            state_d     = mlt_pkg::ST_IDLE;
          end else begin
            pend_d  = res;
            state_d = mlt_pkg::ST_HOLD;
          end
        end
      end
      mlt_pkg::ST_HOLD: begin
        if (out_ready_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = mlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
